FILE: hw/rtl/aes128_pkg.sv
// Shared types, S-box table and round functions for the AES-128 encryption core.
`default_nettype none
package aes128_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ARK,
    ST_ROUND
  } state_t;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    column_mix = t;
  endfunction

  function automatic logic [127:0] expand_row(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w4, w5, w6, w7;
    t = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
    w4 = k[127:96] ^ t;
    w5 = k[95:64] ^ w4;
    w6 = k[63:32] ^ w5;
    w7 = k[31:0] ^ w6;
    expand_row = {w4, w5, w6, w7};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aes128_block_encrypt_core.sv
// Iterative AES-128 encryption core with round keys held in an on-chip memory.
`default_nettype none
// One block is accepted when start is high and busy is low; its ciphertext shows on
// out_valid for one cycle after the initial key addition and one step per round;
// busy drops in that same cycle, so the next block can be taken then. Only one block
// is in work at a time, set by the single round unit and the one-row read port of
// the key memory. After reset or a key write, the first block first expands the key
// into the memory, one round key per cycle, before the initial key addition. The
// result is never held off.
module aes128_block_encrypt_core #(
  parameter int ROUNDS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [63:0]  in_plain_high,
  input  wire logic [63:0]  in_plain_low,
  output logic              out_valid,
  output logic [63:0]       out_cipher_high,
  output logic [63:0]       out_cipher_low,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int RW = $clog2(ROUNDS + 1);
  localparam logic [RW-1:0] LAST = RW'(ROUNDS);

  aes128_pkg::state_t st_r, st_nxt;
  logic [127:0] blk_r, blk_nxt;
  logic [127:0] win_r, win_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic         dirty_r, dirty_nxt;
  logic [63:0]  key_hi_r, key_lo_r;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] cipher_r, cipher_nxt;
  logic         mem_we;
  logic [RW-1:0] rd_addr;
  logic [127:0] rk_q;
  logic [127:0] ss;
  logic         cfg_wr;

  logic [127:0] rk_mem [ROUNDS + 1];

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? key_lo_r : key_hi_r;
  assign busy = (st_r != aes128_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_cipher_high = cipher_r[127:64];
  assign out_cipher_low = cipher_r[63:0];
  assign ss = aes128_pkg::sub_shift(blk_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_mem[cnt_r] <= win_r;
    end
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        key_lo_r <= pwdata;
      end else begin
        key_hi_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aes128_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      round_r <= '0;
    end else begin
      dirty_r <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    win_r <= win_nxt;
    rc_r <= rc_nxt;
    cipher_r <= cipher_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    blk_nxt = blk_r;
    win_nxt = win_r;
    rc_nxt = rc_r;
    cnt_nxt = cnt_r;
    round_nxt = round_r;
    dirty_nxt = dirty_r;
    out_valid_nxt = 1'b0;
    cipher_nxt = cipher_r;
    mem_we = 1'b0;
    rd_addr = '0;
    unique case (st_r)
      aes128_pkg::ST_IDLE: begin
        if (start) begin
          blk_nxt = {in_plain_high, in_plain_low};
          if (dirty_r) begin
            win_nxt = {key_hi_r, key_lo_r};
            rc_nxt = aes128_pkg::RCON_FIRST;
            cnt_nxt = '0;
            dirty_nxt = 1'b0;
            st_nxt = aes128_pkg::ST_EXPAND;
          end else begin
            st_nxt = aes128_pkg::ST_ARK;
          end
        end
      end
      aes128_pkg::ST_EXPAND: begin
        mem_we = 1'b1;
        win_nxt = aes128_pkg::expand_row(win_r, rc_r);
        rc_nxt = aes128_pkg::xtime(rc_r);
        cnt_nxt = cnt_r + RW'(1);
        if (cnt_r == LAST) begin
          st_nxt = aes128_pkg::ST_ARK;
        end
      end
      aes128_pkg::ST_ARK: begin
        blk_nxt = blk_r ^ rk_q;
        rd_addr = RW'(1);
        round_nxt = RW'(1);
        st_nxt = aes128_pkg::ST_ROUND;
      end
      aes128_pkg::ST_ROUND: begin
        if (round_r == LAST) begin
          blk_nxt = ss ^ rk_q;
          cipher_nxt = ss ^ rk_q;
          out_valid_nxt = 1'b1;
          st_nxt = aes128_pkg::ST_IDLE;
        end else begin
          blk_nxt = aes128_pkg::column_mix(ss) ^ rk_q;
          rd_addr = round_r + RW'(1);
          round_nxt = round_r + RW'(1);
        end
      end
      default: begin
        st_nxt = aes128_pkg::ST_IDLE;
      end
    endcase
    if (cfg_wr) begin
      dirty_nxt = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(st_r) == aes128_pkg::ST_ROUND) && ($past(round_r) == LAST))
    else $error("result without final round");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == aes128_pkg::ST_ROUND) |-> (round_r != '0) && (round_r <= LAST))
    else $error("round counter out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start work");

  a_expand_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == aes128_pkg::ST_EXPAND) |-> !dirty_r || $past(cfg_wr))
    else $error("key marked stale during expansion");
`endif

endmodule
`default_nettype wire
